/* src/link_frame_deframer_core_assert.svh */
// Assertion macros shared by the deframer RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef LINK_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define LINK_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lfd_pkg.sv */
// Package for the link frame deframer: status codes, register indexes,
// frame layout constants, burst read record and the CRC16-CCITT byte update.
`default_nettype none

package lfd_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;

  localparam int POS_W = 7;
  localparam int IDX_W = 6;
  localparam int LEN_W = 7;

  localparam logic [1:0] ST_TAKEN   = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FRAME   = 2'd2;

  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_VERSION     = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [7:0] VERSION_RST     = 8'h01;

  localparam logic [POS_W-1:0] P_HUNT    = 7'd0;
  localparam logic [POS_W-1:0] P_SYNC2   = 7'd1;
  localparam logic [POS_W-1:0] P_VERSION = 7'd2;
  localparam logic [POS_W-1:0] P_TYPE    = 7'd3;
  localparam logic [POS_W-1:0] P_LEN_LO  = 7'd4;
  localparam logic [POS_W-1:0] P_LEN_HI  = 7'd5;
  localparam logic [POS_W-1:0] P_SEQ_LO  = 7'd6;
  localparam logic [POS_W-1:0] P_SEQ_HI  = 7'd7;
  localparam logic [POS_W-1:0] P_TS_0    = 7'd8;
  localparam logic [POS_W-1:0] P_TS_1    = 7'd9;
  localparam logic [POS_W-1:0] P_TS_2    = 7'd10;
  localparam logic [POS_W-1:0] P_TS_3    = 7'd11;
  localparam logic [POS_W-1:0] HDR_END   = 7'd12;
  localparam logic [POS_W-1:0] CRC_BYTES = 7'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic             valid;
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic             last;
  } lfd_rd_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/lfd_payload_buf.sv */
// Payload buffer of the deframer: one-port-write, one-port-read memory with a
// registered read, plus the sequencer that streams a completed payload out.
// Depends on lfd_pkg.
`default_nettype none

module lfd_payload_buf
  import lfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic              start,
  input  wire logic [LEN_W-1:0]  start_len,
  input  wire logic              take,
  output logic                   busy,
  output lfd_rd_t                rd
);

  logic [7:0]       mem [MAX_PAYLOAD];
  logic [7:0]       rdata_r;
  logic             busy_r, busy_nxt;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             dv_r, dv_nxt;
  logic [IDX_W-1:0] dv_idx_r;
  logic             rd_en;
  logic             adv;
  logic             dv_last;

  assign dv_last = ({1'b0, dv_idx_r} + 7'd1) == len_r;
  assign adv     = dv_r && take;
  assign rd_en   = busy_r && (rd_idx_r < len_r) && (!dv_r || adv);

  always_comb begin
    busy_nxt   = busy_r;
    rd_idx_nxt = rd_idx_r;
    dv_nxt     = dv_r;
    if (start) begin
      busy_nxt   = 1'b1;
      rd_idx_nxt = '0;
      dv_nxt     = 1'b0;
    end else begin
      if (rd_en) begin
        rd_idx_nxt = rd_idx_r + 7'd1;
        dv_nxt     = 1'b1;
      end else if (adv) begin
        dv_nxt = 1'b0;
      end
      if (adv && dv_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      rd_idx_r <= '0;
      dv_r     <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      rd_idx_r <= rd_idx_nxt;
      dv_r     <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      len_r <= start_len;
    end
    if (rd_en) begin
      dv_idx_r <= rd_idx_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_idx_r[ADDR_W-1:0]];
    end
  end

  assign busy     = busy_r;
  assign rd.valid = dv_r;
  assign rd.data  = rdata_r;
  assign rd.index = dv_idx_r;
  assign rd.last  = dv_last;

endmodule

`default_nettype wire

/* src/link_frame_deframer_core.sv */
// Top level of the link frame deframer: sync hunt, header capture, CRC check
// and result output register. Depends on lfd_pkg, lfd_payload_buf and the
// assertion macro header.
`default_nettype none

// Takes one received byte per transaction and gives one result per byte, except
// on a good frame with a payload of n bytes, which gives n results. While
// hunting, collecting the header and collecting the payload a byte is taken
// every cycle as long as results are taken. After the byte that completes a
// non-empty frame the input stalls while the payload is streamed out of the
// payload memory behind its registered read, one byte per cycle as long as
// results are taken. The payload memory needs no clearing after reset.
module link_frame_deframer_core
  import lfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [7:0]             out_frame_type,
  output logic [LEN_W-1:0]       out_payload_len,
  output logic [15:0]            out_seq_number,
  output logic [31:0]            out_time_stamp,
  output logic [7:0]             out_payload_byte,
  output logic [IDX_W-1:0]       out_payload_index,
  output logic                   out_payload_valid,
  output logic                   out_last
);

  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]       sync_first_r, sync_second_r, version_cfg_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] exp_r, exp_nxt;
  logic [7:0]       ver_r, ver_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [31:0]      ts_r, ts_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [7:0]       out_type_r;
  logic [LEN_W-1:0] out_len_r;
  logic [15:0]      out_seq_r;
  logic [31:0]      out_ts_r;
  logic [7:0]       out_byte_r;
  logic [IDX_W-1:0] out_index_r;
  logic             out_pv_r;
  logic             out_last_r;

  logic             in_fire;
  logic             take;
  logic             burst_busy;
  lfd_rd_t          rd;
  logic             load_in;
  logic             load_burst;
  logic [1:0]       res_status;
  logic             emit_hdr;
  logic             start;
  logic             wr_en;
  logic             frame_good;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] restart_pos;
  logic [15:0]      len_full;
  logic [7:0]       pos_ext;
  logic [7:0]       pay_end;
  logic             covered;
  logic [POS_W-1:0] wr_idx;

  assign take     = !out_valid_r || out_ready;
  assign in_ready = !burst_busy && take;
  assign in_fire  = in_valid && in_ready;

  assign pos_inc     = pos_r + 7'd1;
  assign restart_pos = (in_rx_byte == sync_first_r) ? P_SYNC2 : P_HUNT;
  assign len_full    = {in_rx_byte, len_lo_r};
  assign pos_ext     = {1'b0, pos_r};
  assign pay_end     = {1'b0, HDR_END} + {1'b0, len_r};
  assign covered     = pos_ext < pay_end;
  assign wr_idx      = pos_r - HDR_END;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      version_cfg_r <= VERSION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        CFG_VERSION:     version_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    exp_nxt    = exp_r;
    ver_nxt    = ver_r;
    type_nxt   = type_r;
    len_lo_nxt = len_lo_r;
    len_nxt    = len_r;
    seq_nxt    = seq_r;
    ts_nxt     = ts_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    res_status = ST_TAKEN;
    emit_hdr   = 1'b0;
    start      = 1'b0;
    wr_en      = 1'b0;
    frame_good = 1'b0;
    if (in_fire) begin
      if (pos_r == P_HUNT) begin
        if (in_rx_byte == sync_first_r) begin
          pos_nxt = P_SYNC2;
        end
      end else if (pos_r == P_SYNC2) begin
        if (in_rx_byte == sync_second_r) begin
          pos_nxt = P_VERSION;
          crc_nxt = CRC_INIT;
        end else begin
          pos_nxt = restart_pos;
          exp_nxt = '0;
        end
      end else begin
        if (covered) begin
          crc_nxt = crc16_byte(crc_r, in_rx_byte);
        end
        case (pos_r)
          P_VERSION: ver_nxt          = in_rx_byte;
          P_TYPE:    type_nxt         = in_rx_byte;
          P_LEN_LO:  len_lo_nxt       = in_rx_byte;
          P_LEN_HI:  ;
          P_SEQ_LO:  seq_nxt[7:0]     = in_rx_byte;
          P_SEQ_HI:  seq_nxt[15:8]    = in_rx_byte;
          P_TS_0:    ts_nxt[7:0]      = in_rx_byte;
          P_TS_1:    ts_nxt[15:8]     = in_rx_byte;
          P_TS_2:    ts_nxt[23:16]    = in_rx_byte;
          P_TS_3:    ts_nxt[31:24]    = in_rx_byte;
          default: begin
            if (covered) begin
              wr_en = 1'b1;
            end else if (pos_ext == pay_end) begin
              crc_lo_nxt = in_rx_byte;
            end
          end
        endcase
        pos_nxt = pos_inc;
        if (pos_r == P_LEN_HI) begin
          if (len_full > 16'(MAX_PAYLOAD)) begin
            res_status = ST_INVALID;
            pos_nxt    = restart_pos;
            exp_nxt    = '0;
          end else begin
            len_nxt = len_full[LEN_W-1:0];
            exp_nxt = HDR_END + CRC_BYTES + len_full[LEN_W-1:0];
          end
        end else if ((exp_r != '0) && (pos_inc >= exp_r)) begin
          if ((ver_r != version_cfg_r) || (crc_r != {in_rx_byte, crc_lo_r})) begin
            res_status = ST_INVALID;
            pos_nxt    = restart_pos;
            exp_nxt    = '0;
          end else begin
            frame_good = 1'b1;
            res_status = ST_FRAME;
            pos_nxt    = P_HUNT;
            exp_nxt    = '0;
            if (len_r == '0) begin
              emit_hdr = 1'b1;
            end else begin
              start = 1'b1;
            end
          end
        end
      end
    end
  end

  assign load_in    = in_fire && !start;
  assign load_burst = rd.valid && take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= P_HUNT;
      exp_r    <= '0;
      ver_r    <= '0;
      type_r   <= '0;
      len_lo_r <= '0;
      len_r    <= '0;
      seq_r    <= '0;
      ts_r     <= '0;
      crc_r    <= CRC_INIT;
      crc_lo_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      exp_r    <= exp_nxt;
      ver_r    <= ver_nxt;
      type_r   <= type_nxt;
      len_lo_r <= len_lo_nxt;
      len_r    <= len_nxt;
      seq_r    <= seq_nxt;
      ts_r     <= ts_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_in || load_burst) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_burst) begin
      out_status_r <= ST_FRAME;
      out_type_r   <= type_r;
      out_len_r    <= len_r;
      out_seq_r    <= seq_r;
      out_ts_r     <= ts_r;
      out_byte_r   <= rd.data;
      out_index_r  <= rd.index;
      out_pv_r     <= 1'b1;
      out_last_r   <= rd.last;
    end else if (load_in) begin
      out_status_r <= res_status;
      out_type_r   <= emit_hdr ? type_r : 8'd0;
      out_len_r    <= '0;
      out_seq_r    <= emit_hdr ? seq_r : 16'd0;
      out_ts_r     <= emit_hdr ? ts_r : 32'd0;
      out_byte_r   <= '0;
      out_index_r  <= '0;
      out_pv_r     <= 1'b0;
      out_last_r   <= 1'b1;
    end
  end

  lfd_payload_buf #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .ADDR_W      (ADDR_W)
  ) u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_idx[ADDR_W-1:0]),
    .wr_data   (in_rx_byte),
    .start     (start),
    .start_len (len_r),
    .take      (take),
    .busy      (burst_busy),
    .rd        (rd)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_frame_type    = out_type_r;
  assign out_payload_len   = out_len_r;
  assign out_seq_number    = out_seq_r;
  assign out_time_stamp    = out_ts_r;
  assign out_payload_byte  = out_byte_r;
  assign out_payload_index = out_index_r;
  assign out_payload_valid = out_pv_r;
  assign out_last          = out_last_r;

`include "link_frame_deframer_core_assert.svh"

  `LFD_ASSERT_NOW(a_len_window, (exp_r != '0), ((pos_r >= P_SEQ_LO) && (pos_r < exp_r)), "frame position outside the known frame length")
  `LFD_ASSERT_NEXT(a_burst_start, (frame_good && (len_r != '0)), (burst_busy && !in_ready), "payload burst did not start after a good frame")
  `LFD_ASSERT_NEXT(a_burst_end, (load_burst && rd.last), (!burst_busy), "payload burst still busy after its last byte")

endmodule

`default_nettype wire
